// ===== hw/rtl/vdi_pkg.sv =====
// Package for the vertex deduplication indexer.
// Holds table sizing constants, the sequencer state type and a float equality function; no dependencies.
package vdi_pkg;
  localparam int TableDepth = 1024;
  localparam int AddrW = $clog2(TableDepth);
  localparam int CountW = $clog2(TableDepth + 1);
  localparam int KeyW = 160;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK
  } state_t;

  // Floating-point equality of two single-precision bit patterns.
  function automatic logic feq(input logic [31:0] a, input logic [31:0] b);
    logic nan_a;
    logic nan_b;
    nan_a = (a[30:0] > 31'h7F800000);
    nan_b = (b[30:0] > 31'h7F800000);
    feq = !nan_a && !nan_b && ((a == b) || ((a[30:0] | b[30:0]) == 31'd0));
  endfunction
endpackage

// ===== hw/rtl/vdi_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module vdi_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Read-first style: a read during a write returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hw/rtl/vertex_dedup_indexer.sv =====
// Top level of the vertex deduplication indexer.
// Depends on vdi_pkg and vdi_ram.
//
// A request is taken when start is high and busy is low. The block scans its key
// table in insertion order through a single RAM read port and one shared five-lane
// float compare, reading each stored entry and then checking it. Busy is low in
// the cycle the result is shown, so the next request can be taken at the edge
// that ends it. The result appears for exactly one cycle with out_valid high and
// cannot be held off. No clearing pass is needed after reset.
module vertex_dedup_indexer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_tex_u,
  input  logic [31:0] in_tex_v,
  input  logic [31:0] in_color_r,
  input  logic [31:0] in_color_g,
  input  logic [31:0] in_color_b,
  output logic        out_valid,
  output logic [9:0]  out_vertex_index,
  output logic        out_is_new,
  output logic        out_table_full,
  output logic [10:0] out_unique_count
);
  import vdi_pkg::*;

  state_t state_r, state_nxt;
  logic [CountW-1:0] count_r, count_nxt;
  logic [CountW-1:0] ptr_r, ptr_nxt;
  logic [KeyW-1:0] key_r;
  logic [AddrW-1:0] ram_addr;
  logic ram_we;
  logic [KeyW-1:0] ram_rdata;
  logic hit;
  logic valid_nxt, new_nxt, full_nxt;
  logic [9:0] idx_nxt;
  logic [10:0] ucnt_nxt;
  logic [CountW-1:0] cmp_idx;

  // Key table: x, y, z, u, v.
  vdi_ram #(.Width(KeyW), .Depth(TableDepth)) u_keys (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(key_r), .rdata(ram_rdata)
  );

  // Shared five-lane compare on the entry read last cycle.
  assign hit = feq(ram_rdata[159:128], key_r[159:128]) && feq(ram_rdata[127:96], key_r[127:96])
            && feq(ram_rdata[95:64], key_r[95:64]) && feq(ram_rdata[63:32], key_r[63:32])
            && feq(ram_rdata[31:0], key_r[31:0]);
  assign cmp_idx = ptr_r - CountW'(1);

  // Capture the key on a request; color is not kept.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      key_r <= {in_pos_x, in_pos_y, in_pos_z, in_tex_u, in_tex_v};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      ptr_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      ptr_r     <= ptr_nxt;
      out_valid <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_vertex_index <= idx_nxt;
    out_is_new       <= new_nxt;
    out_table_full   <= full_nxt;
    out_unique_count <= ucnt_nxt;
  end

  // Sequencer: read entry ptr, check it next cycle; on a miss append or flag full.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ptr_nxt   = ptr_r;
    valid_nxt = 1'b0;
    new_nxt   = 1'b0;
    full_nxt  = 1'b0;
    idx_nxt   = '0;
    ucnt_nxt  = 11'(count_r);
    ram_we    = 1'b0;
    ram_addr  = ptr_r[AddrW-1:0];
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          ptr_nxt   = '0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue a read, or finish when every entry has been issued.
        if (ptr_r < count_r) begin
          ptr_nxt   = ptr_r + CountW'(1);
          state_nxt = ST_CHECK;
        end else if (count_r >= CountW'(TableDepth)) begin
          valid_nxt = 1'b1;
          full_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ram_we    = 1'b1;
          ram_addr  = count_r[AddrW-1:0];
          count_nxt = count_r + CountW'(1);
          valid_nxt = 1'b1;
          new_nxt   = 1'b1;
          idx_nxt   = 10'(count_r);
          ucnt_nxt  = 11'(count_r + CountW'(1));
          state_nxt = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (hit) begin
          valid_nxt = 1'b1;
          idx_nxt   = 10'(cmp_idx);
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // The entry count never passes the table depth.
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CountW'(TableDepth))
    else $error("entry count overflow");
  // A new entry raises the count by one.
  assert property (@(posedge clk) disable iff (!rst_n) ram_we |=> count_r == $past(count_r) + 1)
    else $error("count not advanced on append");
  // A result is never both new and full.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> !(out_is_new && out_table_full))
    else $error("new and full together");
  // The scan pointer never runs past the count.
  assert property (@(posedge clk) disable iff (!rst_n) ptr_r <= count_r)
    else $error("scan pointer past count");
endmodule

// ===== test/vdi_checker.sv =====
// Checker for the vertex deduplication indexer: watches the request and result
// ports, predicts each lookup and compares. Depends on vdi_pkg for table sizing.
module vdi_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_pos_x,
  input  logic [31:0] in_pos_y,
  input  logic [31:0] in_pos_z,
  input  logic [31:0] in_tex_u,
  input  logic [31:0] in_tex_v,
  input  logic        out_valid,
  input  logic [9:0]  out_vertex_index,
  input  logic        out_is_new,
  input  logic        out_table_full,
  input  logic [10:0] out_unique_count,
  output int          err_count,
  output int          pending
);
  import vdi_pkg::*;

  typedef struct packed {
    logic [AddrW-1:0]  vertex_index;
    logic              is_new;
    logic              table_full;
    logic [CountW-1:0] unique_count;
  } lookup_t;

  // Predicted copy of the key table, x,y,z,u,v packed from the low bits up.
  logic [159:0] key_store [TableDepth];
  int           stored_keys;
  lookup_t      lookup_q[$];

  initial err_count = 0;
  assign pending = lookup_q.size();

  // Float equality: NaN never matches, signed zeros do.
  function automatic logic flt_equal(input logic [31:0] a, input logic [31:0] b);
    logic a_nan;
    logic b_nan;
    a_nan = a[30:0] > 31'h7F800000;
    b_nan = b[30:0] > 31'h7F800000;
    if (a_nan || b_nan) return 1'b0;
    return (a == b) || ((a[30:0] | b[30:0]) == 31'd0);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
    err_count++;
  endtask

  // Scan in insertion order; append on a miss while space remains.
  task automatic predict_lookup(input logic [159:0] key, output lookup_t res);
    int   i;
    logic hit;
    res = '0;
    for (i = 0; i < stored_keys; i++) begin
      hit = 1'b1;
      for (int c = 0; c < 5; c++)
        if (!flt_equal(key_store[i][c*32 +: 32], key[c*32 +: 32])) hit = 1'b0;
      if (hit) begin
        res.vertex_index = i[AddrW-1:0];
        res.unique_count = stored_keys[CountW-1:0];
        return;
      end
    end
    if (stored_keys >= TableDepth) begin
      res.table_full = 1'b1;
      res.unique_count = stored_keys[CountW-1:0];
      return;
    end
    key_store[stored_keys] = key;
    res.vertex_index = stored_keys[AddrW-1:0];
    res.is_new = 1'b1;
    stored_keys++;
    res.unique_count = stored_keys[CountW-1:0];
  endtask

  always @(posedge clk) begin
    lookup_t res;
    lookup_t want;
    if (!rst_n) begin
      stored_keys = 0;
      lookup_q.delete();
    end else begin
      // Compare a result against the oldest outstanding request.
      if (out_valid) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("unexpected result, index", out_vertex_index, 0);
        end else begin
          want = lookup_q.pop_front();
          if (out_table_full != want.table_full)
            report_mismatch("table_full", out_table_full, want.table_full);
          if (out_is_new != want.is_new)
            report_mismatch("is_new", out_is_new, want.is_new);
          if (out_unique_count != want.unique_count)
            report_mismatch("unique_count", out_unique_count, want.unique_count);
          if (out_vertex_index != want.vertex_index)
            report_mismatch("vertex_index", out_vertex_index, want.vertex_index);
        end
      end
      // Predict each accepted request.
      if (start && !busy) begin
        predict_lookup({in_tex_v, in_tex_u, in_pos_z, in_pos_y, in_pos_x}, res);
        lookup_q = {lookup_q, res};
      end
    end
  end
endmodule

// ===== test/tb_vertex_dedup_indexer.sv =====
// Testbench top for the vertex deduplication indexer: makes requests and gives
// the verdict. Depends on vdi_pkg, vdi_checker and the block itself.
module tb_vertex_dedup_indexer;
  import vdi_pkg::*;

  localparam int CycleLimit = 4000000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] pos_x, pos_y, pos_z, tex_u, tex_v;
  logic [31:0] col_r, col_g, col_b;
  logic        out_valid;
  logic [9:0]  out_vertex_index;
  logic        out_is_new;
  logic        out_table_full;
  logic [10:0] out_unique_count;
  int          err_count;
  int          pending;
  int          cycle_count = 0;
  logic        idling_on;

  // Keys sent so far, packed x,y,z,u,v from the low bits up, for building repeats.
  logic [159:0] sent_keys[$];

  vertex_dedup_indexer u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(pos_x), .in_pos_y(pos_y), .in_pos_z(pos_z),
    .in_tex_u(tex_u), .in_tex_v(tex_v),
    .in_color_r(col_r), .in_color_g(col_g), .in_color_b(col_b),
    .out_valid(out_valid), .out_vertex_index(out_vertex_index),
    .out_is_new(out_is_new), .out_table_full(out_table_full),
    .out_unique_count(out_unique_count)
  );

  vdi_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(pos_x), .in_pos_y(pos_y), .in_pos_z(pos_z),
    .in_tex_u(tex_u), .in_tex_v(tex_v),
    .out_valid(out_valid), .out_vertex_index(out_vertex_index),
    .out_is_new(out_is_new), .out_table_full(out_table_full),
    .out_unique_count(out_unique_count),
    .err_count(err_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Guard the run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Raw bits most often, plus zeros, a NaN, infinity and a small pool so keys collide.
  function automatic logic [31:0] pick_component();
    case ($urandom_range(0, 9))
      0: return 32'h0000_0000;
      1: return 32'h8000_0000;
      2: return 32'h7FC0_0000;
      3: return 32'h7F80_0000;
      4, 5: return 32'h3F80_0000 + $urandom_range(0, 2);
      default: return $urandom();
    endcase
  endfunction

  // Send one request and wait for it to be taken, then idle a random while if idling is on.
  task automatic send_vertex(input logic [159:0] key);
    int gap;
    pos_x <= key[31:0];
    pos_y <= key[63:32];
    pos_z <= key[95:64];
    tex_u <= key[127:96];
    tex_v <= key[159:128];
    col_r <= $urandom();
    col_g <= $urandom();
    col_b <= $urandom();
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sent_keys = {sent_keys, key};
    gap = idling_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Repeat an earlier key, sometimes flipping the sign of zero components.
  function automatic logic [159:0] repeat_key();
    logic [159:0] key;
    key = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
    for (int c = 0; c < 5; c++)
      if (key[c*32 +: 31] == 31'd0 && $urandom_range(0, 1)) key[c*32 + 31] ^= 1'b1;
    return key;
  endfunction

  function automatic logic [159:0] fresh_key();
    return {pick_component(), pick_component(), pick_component(),
            pick_component(), pick_component()};
  endfunction

  initial begin
    idling_on = 1'b1;
    rst_n = 1'b0;
    start = 1'b0;
    {pos_x, pos_y, pos_z, tex_u, tex_v, col_r, col_g, col_b} = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zeros, signed zero, NaN, infinities, extremes, colour-only change.
    send_vertex('0);
    send_vertex({5{32'h8000_0000}});
    send_vertex({5{32'hFFFF_FFFF}});
    send_vertex({5{32'hFFFF_FFFF}});
    send_vertex({5{32'h7F80_0000}});
    send_vertex({5{32'hFF80_0000}});
    send_vertex({5{32'h7F7F_FFFF}});
    send_vertex({5{32'h7F7F_FFFF}});
    send_vertex({32'h7FC0_0000, {4{32'h3F80_0000}}});
    send_vertex({32'h3F80_0000, {4{32'h3F80_0000}}});
    send_vertex({32'h4000_0000, {4{32'h3F80_0000}}});
    send_vertex({{4{32'h3F80_0000}}, 32'h0000_0001});
    send_vertex({{4{32'h3F80_0000}}, 32'h0000_0001});
    send_vertex({32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0});
    send_vertex({5{32'hAAAA_AAAA}});
    send_vertex({5{32'h5555_5555}});
    send_vertex({5{32'h7F80_0001}});

    // Random: repeats of earlier keys and fresh keys, with stretches of no idling.
    for (int n = 0; n < 430; n++) begin
      if (n % 50 == 0) idling_on = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 9) < 4) send_vertex(repeat_key());
      else send_vertex(fresh_key());
    end

    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TableDepth + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
